// File: hdl/stochastic_raw_value_unit_assert.svh
// ---------------------------------------------------------------------------
// stochastic raw value unit assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef STOCHASTIC_RAW_VALUE_UNIT_ASSERT_SVH
`define STOCHASTIC_RAW_VALUE_UNIT_ASSERT_SVH

// same-cycle implication
`define SRV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/srv_pkg.sv
// ---------------------------------------------------------------------------
// srv_pkg
// shared constants, types and helpers of the stochastic raw value unit
// ---------------------------------------------------------------------------
package srv_pkg;

  // window store geometry
  localparam int WINDOW_MAX = 64;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);

  // field widths
  localparam int CFG_W   = 7;
  localparam int PRICE_W = 32;
  localparam int RSV_W   = 14;
  localparam int DIFF_W  = PRICE_W + 1;
  localparam int PROD_W  = PRICE_W + RSV_W;
  localparam int CNT_W   = $clog2(RSV_W + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(9);
  localparam logic [RSV_W-1:0] RSV_SCALE = RSV_W'(10000);

  // main sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIFF,
    ST_SIGN,
    ST_LAUNCH,
    ST_DIV,
    ST_FIN
  } srv_state_t;

  // divider states
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_RUN,
    DIV_DONE
  } srv_div_state_t;

  // request into the divider
  typedef struct packed {
    logic               start;
    logic [PRICE_W-1:0] num_mag;
    logic [PRICE_W-1:0] den_mag;
  } srv_div_req_t;

  // response from the divider
  typedef struct packed {
    logic             done;
    logic [RSV_W-1:0] quot;
  } srv_div_rsp_t;

  // ring slot stepping with wrap
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(WINDOW_MAX - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == '0) begin
      r = SLOT_W'(WINDOW_MAX - 1);
    end else begin
      r = s - SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

// File: hdl/stochastic_raw_value_unit.sv
// ---------------------------------------------------------------------------
// stochastic_raw_value_unit
// raw stochastic value (%K) of each price bar over a sliding high/low window
// ---------------------------------------------------------------------------
// usage
//   input channel in_*: one bar per transaction (high, low, close, start).
//   in_start_series begins a new series with this bar. in_stall is high while
//   a bar is being worked on, so one bar is taken at a time.
//   result channel out_*: zero or one transaction per bar; none until the
//   series holds window_length bars. the result sits in an output register,
//   so the next bar can be taken while out_stall holds the previous result.
//   cfg_wr_en/cfg_wr_data write window_length (1..64, reset 9) while idle.
//   steps: for a bar that gives a result, the ring walk reads one stored
//   bar a cycle from a single read port, then the difference and sign
//   steps follow; a saturated, zero or flat window then finishes, else
//   the divider runs (launch, multiply, 14 quotient bits, done). a result
//   stalled at the output holds the block in its final step until the
//   register frees.
//   reset: empty series, write slot 0, window_length 9, ring contents unused
//   until written again.
// ---------------------------------------------------------------------------
module stochastic_raw_value_unit
  import srv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PRICE_W-1:0] in_bar_high,
  input  logic [PRICE_W-1:0] in_bar_low,
  input  logic [PRICE_W-1:0] in_bar_close,
  input  logic               in_start_series,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RSV_W-1:0]   out_rsv_value,
  output logic               out_flat_window
);

`include "stochastic_raw_value_unit_assert.svh"

  srv_state_t state_r, state_nxt;

  logic [CFG_W-1:0]   cfg_len_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [LEN_W-1:0]   held_r;
  logic [SLOT_W-1:0]  rd_addr_r;
  logic [LEN_W-1:0]   rd_left_r;
  logic               pend_r;

  logic [PRICE_W-1:0] wh_r;
  logic [PRICE_W-1:0] wl_r;
  logic [PRICE_W-1:0] close_r;
  logic [DIFF_W-1:0]  num_r;
  logic [DIFF_W-1:0]  den_r;
  logic [PRICE_W-1:0] mag_a_r;
  logic [PRICE_W-1:0] mag_d_r;
  logic [RSV_W-1:0]   val_r;
  logic               flat_r;

  logic               out_valid_r;
  logic [RSV_W-1:0]   out_rsv_value_r;
  logic               out_flat_window_r;

  logic               accept;
  logic [SLOT_W-1:0]  base_slot;
  logic [LEN_W-1:0]   held_new;
  logic [LEN_W-1:0]   len_eff;
  logic               go;
  logic               issue;
  logic               out_load;

  logic               num_neg;
  logic               den_neg;
  logic [PRICE_W-1:0] mag_a;
  logic [PRICE_W-1:0] mag_d;
  logic               sign_flat;
  logic               sign_zero;
  logic               sign_sat;

  logic [PRICE_W-1:0] rd_high;
  logic [PRICE_W-1:0] rd_low;

  srv_div_req_t       div_req;
  srv_div_rsp_t       div_rsp;

  // transaction accept and series bookkeeping
  assign accept    = in_valid && !in_stall;
  assign base_slot = in_start_series ? '0 : slot_r;

  always_comb begin
    if (in_start_series) begin
      held_new = LEN_W'(1);
    end else if (held_r == LEN_W'(WINDOW_MAX)) begin
      held_new = held_r;
    end else begin
      held_new = held_r + LEN_W'(1);
    end
  end

  // effective window length, clamped to 1..WINDOW_MAX
  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg_len_r) > WINDOW_MAX) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = LEN_W'(cfg_len_r);
    end
  end

  assign go = (held_new >= len_eff);

  // ring stores for highs and lows
  srv_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW_MAX)
  ) u_high_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (base_slot),
    .wdata (in_bar_high),
    .raddr (rd_addr_r),
    .rdata (rd_high)
  );

  srv_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW_MAX)
  ) u_low_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (base_slot),
    .wdata (in_bar_low),
    .raddr (rd_addr_r),
    .rdata (rd_low)
  );

  // sign and magnitude of the registered differences
  assign num_neg   = num_r[DIFF_W-1];
  assign den_neg   = den_r[DIFF_W-1];
  assign mag_a     = num_neg ? PRICE_W'(-num_r) : num_r[PRICE_W-1:0];
  assign mag_d     = den_neg ? PRICE_W'(-den_r) : den_r[PRICE_W-1:0];
  assign sign_flat = (den_r == '0);
  assign sign_zero = (num_r == '0) || (num_neg != den_neg);
  assign sign_sat  = (mag_a >= mag_d);

  // divider, used in the divide step
  srv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && go) begin
          state_nxt = (len_eff == LEN_W'(1)) ? ST_DIFF : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_left_r == '0 && !pend_r) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        if (sign_flat || sign_zero || sign_sat) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall        = 1'b1;
    issue           = 1'b0;
    div_req.start   = 1'b0;
    div_req.num_mag = mag_a_r;
    div_req.den_mag = mag_d_r;
    out_load        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SCAN: begin
        issue = (rd_left_r != '0);
      end
      ST_LAUNCH: begin
        div_req.start = 1'b1;
      end
      ST_FIN: begin
        out_load = !out_valid_r || !out_stall;
      end
      ST_DIFF, ST_SIGN, ST_DIV: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_len_r   <= CFG_RESET;
      slot_r      <= '0;
      held_r      <= '0;
      rd_left_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      if (accept) begin
        slot_r    <= slot_inc(base_slot);
        held_r    <= held_new;
        rd_left_r <= len_eff - LEN_W'(1);
      end else if (issue) begin
        rd_left_r <= rd_left_r - LEN_W'(1);
      end
      pend_r <= issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // window walk, differences and result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      wh_r      <= in_bar_high;
      wl_r      <= in_bar_low;
      close_r   <= in_bar_close;
      rd_addr_r <= slot_dec(base_slot);
    end else begin
      if (issue) begin
        rd_addr_r <= slot_dec(rd_addr_r);
      end
      if (pend_r) begin
        if (rd_high > wh_r) begin
          wh_r <= rd_high;
        end
        if (rd_low < wl_r) begin
          wl_r <= rd_low;
        end
      end
    end
    if (state_r == ST_DIFF) begin
      num_r <= DIFF_W'(close_r) - DIFF_W'(wl_r);
      den_r <= DIFF_W'(wh_r) - DIFF_W'(wl_r);
    end
    if (state_r == ST_SIGN) begin
      mag_a_r <= mag_a;
      mag_d_r <= mag_d;
      flat_r  <= sign_flat;
      if (sign_flat || sign_zero) begin
        val_r <= '0;
      end else begin
        val_r <= RSV_SCALE;
      end
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      val_r <= div_rsp.quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rsv_value_r   <= val_r;
      out_flat_window_r <= flat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rsv_value   = out_rsv_value_r;
  assign out_flat_window = out_flat_window_r;

  // checks
  `SRV_ASSERT_IMP(a_value_range, out_valid_r, out_rsv_value_r <= RSV_SCALE, "rsv above scale")
  `SRV_ASSERT_IMP(a_flat_zero, out_valid_r && out_flat_window_r, out_rsv_value_r == '0,
                  "flat window with nonzero value")
  `SRV_ASSERT_IMP(a_div_done_state, div_rsp.done, state_r == ST_DIV,
                  "divider finished outside divide step")
  `SRV_ASSERT_NXT(a_fin_holds, state_r == ST_FIN && out_valid_r && out_stall,
                  state_r == ST_FIN, "result left final step while output busy")

endmodule

// File: hdl/srv_ram.sv
// ---------------------------------------------------------------------------
// srv_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module srv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/srv_div.sv
// ---------------------------------------------------------------------------
// srv_div
// scales the numerator magnitude by 10000 and runs a restoring division,
// one quotient bit per cycle; the quotient is known to stay below 10000
// ---------------------------------------------------------------------------
module srv_div
  import srv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  srv_div_req_t req,
  output srv_div_rsp_t rsp
);

  srv_div_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic [PRICE_W-1:0] a_r;
  logic [PRICE_W-1:0] d_r;
  logic [PRICE_W-1:0] rem_r;
  logic [RSV_W-1:0]   lo_r;
  logic [RSV_W-1:0]   q_r;

  logic [PROD_W-1:0]  prod;
  logic [PRICE_W:0]   trial;
  logic [PRICE_W:0]   den_ext;
  logic               ge;

  // scaled numerator
  assign prod = PROD_W'(a_r) * PROD_W'(RSV_SCALE);

  // one restoring step
  assign trial   = {rem_r, lo_r[RSV_W-1]};
  assign den_ext = {1'b0, d_r};
  assign ge      = (trial >= den_ext);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: begin
        if (req.start) begin
          state_nxt = DIV_MUL;
        end
      end
      DIV_MUL: begin
        state_nxt = DIV_RUN;
      end
      DIV_RUN: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        state_nxt = DIV_IDLE;
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = 1'b0;
    rsp.quot = q_r;
    unique case (state_r)
      DIV_DONE: begin
        rsp.done = 1'b1;
      end
      DIV_IDLE, DIV_MUL, DIV_RUN: begin
        rsp.done = 1'b0;
      end
      default: begin
        rsp.done = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == DIV_MUL) begin
        cnt_r <= CNT_W'(RSV_W);
      end else if (state_r == DIV_RUN) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // operand, remainder and quotient registers
  always_ff @(posedge clk) begin
    if (state_r == DIV_IDLE && req.start) begin
      a_r <= req.num_mag;
      d_r <= req.den_mag;
    end
    if (state_r == DIV_MUL) begin
      rem_r <= prod[PROD_W-1:RSV_W];
      lo_r  <= prod[RSV_W-1:0];
      q_r   <= '0;
    end else if (state_r == DIV_RUN) begin
      rem_r <= ge ? PRICE_W'(trial - den_ext) : trial[PRICE_W-1:0];
      lo_r  <= {lo_r[RSV_W-2:0], 1'b0};
      q_r   <= {q_r[RSV_W-2:0], ge};
    end
  end

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// checks stochastic_raw_value_unit against an independent %K predictor.
// price bars go in over a valid/stall channel; every bar is run through
// the predictor's own window stores. each result from the block is compared
// field by field with the oldest outstanding expectation. the window length
// register is moved through its extremes between phases. both sides idle at
// random, and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module testbench
  import srv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BARS   = 190;
  localparam longint K_SCALE  = 10000;

  typedef struct {
    logic [PRICE_W-1:0] bar_hi;
    logic [PRICE_W-1:0] bar_lo;
    logic [PRICE_W-1:0] bar_cl;
    logic               start;
  } bar_t;

  typedef struct {
    logic [RSV_W-1:0] rsv;
    logic             flat;
  } k_result_t;

  // window predictor with its own copy of the stores and the length register
  class percent_k_tracker;
    logic [PRICE_W-1:0] high_ring [WINDOW_MAX];
    logic [PRICE_W-1:0] low_ring  [WINDOW_MAX];
    int unsigned        write_slot;
    int unsigned        bars_held;
    logic [CFG_W-1:0]   window_length;
    k_result_t          due_k [$];
    int                 mismatches;

    function new();
      write_slot    = 0;
      bars_held     = 0;
      window_length = CFG_RESET;
      mismatches    = 0;
    endfunction

    // store the bar and work out the %K it gives, if the window is full
    function void note_bar(bar_t b);
      int unsigned        span_len;
      int unsigned        slot;
      int unsigned        k;
      logic [PRICE_W-1:0] win_hi;
      logic [PRICE_W-1:0] win_lo;
      longint             num;
      longint             den;
      longint             quot;
      longint             cl64;
      longint             lo64;
      longint             hi64;
      k_result_t          r;
      if (b.start) begin
        write_slot = 0;
        bars_held  = 0;
      end
      slot             = write_slot;
      high_ring[slot]  = b.bar_hi;
      low_ring[slot]   = b.bar_lo;
      write_slot       = (slot + 1) % WINDOW_MAX;
      if (bars_held < WINDOW_MAX) begin
        bars_held++;
      end
      // zero acts as one, anything past the store depth as the full depth
      if (window_length == 0) begin
        span_len = 1;
      end else if (window_length > WINDOW_MAX) begin
        span_len = WINDOW_MAX;
      end else begin
        span_len = window_length;
      end
      if (bars_held < span_len) begin
        return;
      end
      win_hi = b.bar_hi;
      win_lo = b.bar_lo;
      for (int i = 1; i < span_len; i++) begin
        k = (slot + WINDOW_MAX - i) % WINDOW_MAX;
        if (high_ring[k] > win_hi) begin
          win_hi = high_ring[k];
        end
        if (low_ring[k] < win_lo) begin
          win_lo = low_ring[k];
        end
      end
      if (win_hi == win_lo) begin
        r.rsv  = '0;
        r.flat = 1'b1;
      end else begin
        // signed so that an inverted window truncates toward zero
        cl64 = b.bar_cl;
        lo64 = win_lo;
        hi64 = win_hi;
        num  = (cl64 - lo64) * K_SCALE;
        den  = hi64 - lo64;
        quot = num / den;
        if (quot < 0) begin
          quot = 0;
        end
        if (quot > K_SCALE) begin
          quot = K_SCALE;
        end
        r.rsv  = RSV_W'(quot);
        r.flat = 1'b0;
      end
      due_k.insert(due_k.size(), r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // compare one result transaction with the oldest expectation
    task check_result(logic [RSV_W-1:0] rsv, logic flat);
      k_result_t e;
      if (due_k.size() == 0) begin
        report_mismatch($sformatf("result rsv=%0d flat=%0b with nothing due", rsv, flat));
        return;
      end
      e = due_k.pop_front();
      if (rsv !== e.rsv) begin
        report_mismatch($sformatf("rsv_value got %0d want %0d", rsv, e.rsv));
      end
      if (flat !== e.flat) begin
        report_mismatch($sformatf("flat_window got %0b want %0b", flat, e.flat));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [CFG_W-1:0]   cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [PRICE_W-1:0] in_bar_high;
  logic [PRICE_W-1:0] in_bar_low;
  logic [PRICE_W-1:0] in_bar_close;
  logic               in_start_series;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RSV_W-1:0]   out_rsv_value;
  logic               out_flat_window;

  percent_k_tracker   k_track;
  bit                 steady;
  bit                 hold_request;
  int unsigned        hold_left;
  int unsigned        cycle_count;
  logic [PRICE_W-1:0] price_level;
  int unsigned        flat_run;

  stochastic_raw_value_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_bar_high     (in_bar_high),
    .in_bar_low      (in_bar_low),
    .in_bar_close    (in_bar_close),
    .in_start_series (in_start_series),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rsv_value   (out_rsv_value),
    .out_flat_window (out_flat_window)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 13);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      k_track.check_result(out_rsv_value, out_flat_window);
    end
  end

  // offer one bar, with random idle cycles ahead of it; called at a falling edge
  task automatic send_bar(bar_t b);
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_bar_high     <= b.bar_hi;
    in_bar_low      <= b.bar_lo;
    in_bar_close    <= b.bar_cl;
    in_start_series <= b.start;
    do begin
      @(posedge clk);
    end while (in_stall);
    k_track.note_bar(b);
    @(negedge clk);
  endtask

  task automatic send(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                      logic [PRICE_W-1:0] cl, logic start);
    bar_t b;
    b.bar_hi = hi;
    b.bar_lo = lo;
    b.bar_cl = cl;
    b.start  = start;
    send_bar(b);
  endtask

  // wait for every due result, then for the block to finish a silent bar
  task automatic settle();
    in_valid <= 1'b0;
    while (k_track.due_k.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    k_track.window_length = len;
  endtask

  // mostly a drifting price series, some broken and raw bars
  function automatic bar_t random_bar();
    bar_t        b;
    int unsigned pick;
    int unsigned span;
    pick    = $urandom_range(99);
    b.start = ($urandom_range(199) == 0);
    if (b.start) begin
      price_level = $urandom;
    end
    // occasional run of identical flat bars long enough to fill any window
    if (flat_run == 0 && $urandom_range(99) == 0) begin
      flat_run = 70;
    end
    if (flat_run > 0) begin
      flat_run--;
      b.bar_hi = price_level;
      b.bar_lo = price_level;
      b.bar_cl = ($urandom_range(3) == 0) ? $urandom : price_level;
      return b;
    end
    price_level = price_level + $urandom_range(200) - 100;
    case ($urandom_range(19))
      0:       span = 0;
      1, 2, 3: span = $urandom_range(32'h7fff_ffff);
      default: span = $urandom_range(1, 500);
    endcase
    b.bar_hi = price_level + $urandom_range(span);
    b.bar_lo = price_level - $urandom_range(span);
    b.bar_cl = b.bar_lo + $urandom_range(b.bar_hi - b.bar_lo);
    if (pick >= 75 && pick < 85) begin
      b.bar_cl = $urandom;
    end else if (pick >= 85 && pick < 92) begin
      b.bar_hi = b.bar_lo;
      b.bar_lo = price_level + $urandom_range(span) + 1;
    end else if (pick >= 92 && pick < 96) begin
      b.bar_hi = ($urandom_range(1) == 0) ? '0 : '1;
      b.bar_lo = ($urandom_range(2) == 0) ? '0 : (($urandom_range(1) == 0) ? '1 : $urandom);
      b.bar_cl = ($urandom_range(2) == 0) ? '1 : (($urandom_range(1) == 0) ? '0 : $urandom);
    end else if (pick >= 96) begin
      b.bar_hi = $urandom;
      b.bar_lo = $urandom;
      b.bar_cl = $urandom;
    end
    return b;
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_len [8];
    k_track         = new();
    steady          = 1'b0;
    hold_request    = 1'b0;
    hold_left       = 0;
    cycle_count     = 0;
    flat_run        = 0;
    price_level     = 32'd100_000;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_bar_high     = '0;
    in_bar_low      = '0;
    in_bar_close    = '0;
    in_start_series = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-bar window: extremes, flat, close outside, inverted bars
    write_window(CFG_W'(1));
    send('1, '0, '1, 1'b1);
    send('1, '0, '0, 1'b0);
    send(32'd5, 32'd5, 32'd7, 1'b0);
    send('1, '1, '0, 1'b0);
    send(32'd100, 32'd50, 32'd200, 1'b0);
    send(32'd100, 32'd50, 32'd0, 1'b0);
    send(32'd50, 32'd100, 32'd75, 1'b0);
    send('0, '1, '0, 1'b0);
    send(32'd1000, 32'd0, 32'd333, 1'b0);
    settle();

    // zero length behaves as one
    write_window('0);
    send(32'd200, 32'd100, 32'd150, 1'b0);
    send(32'd200, 32'd100, 32'd199, 1'b0);
    settle();

    // three-bar window: filling, then a restart part way through
    write_window(CFG_W'(3));
    send(32'd10, 32'd0, 32'd5, 1'b1);
    send(32'd20, 32'd5, 32'd10, 1'b0);
    send(32'd30, 32'd10, 32'd30, 1'b0);
    send(32'd100, 32'd0, 32'd50, 1'b1);
    send(32'd100, 32'd0, 32'd50, 1'b0);
    send(32'd100, 32'd0, 32'd25, 1'b0);
    settle();

    // random phases; the series carries over each length change
    phase_len = '{CFG_W'(64), CFG_W'(2), CFG_W'(127), CFG_W'(9),
                  CFG_W'(1), CFG_W'(0), CFG_W'($urandom_range(127)),
                  CFG_W'($urandom_range(1, 20))};
    for (int p = 0; p < 8; p++) begin
      write_window(phase_len[p]);
      steady = (p == 3);
      for (int n = 0; n < PHASE_BARS; n++) begin
        // long receiver hold-off while bars keep coming
        if (p == 1 && n == 40) begin
          hold_request = 1'b1;
        end
        send_bar(random_bar());
      end
      settle();
    end
    steady = 1'b0;

    if (k_track.due_k.size() != 0) begin
      k_track.report_mismatch($sformatf("%0d results never came", k_track.due_k.size()));
    end
    if (k_track.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/srv_pkg.sv
hdl/srv_ram.sv
hdl/srv_div.sv
hdl/stochastic_raw_value_unit.sv
test/testbench.sv
